>>> rtl/core/tpq_pkg.sv
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared sizes, codes, memory word layouts and helpers of the tree path
// min/max query block.
// ----------------------------------------------------------------------------
package tpq_pkg;

  // tree capacity and lifting levels
  localparam int MAX_NODES   = 1024;
  localparam int LIFT_LEVELS = 11;
  localparam int EDGE_CAP    = MAX_NODES - 1;

  // field and index widths
  localparam int NODE_W    = 11;
  localparam int WEIGHT_W  = 32;
  localparam int DEPTH_W   = $clog2(MAX_NODES);
  localparam int LVL_W     = $clog2(LIFT_LEVELS);
  localparam int NODE_AW   = $clog2(MAX_NODES + 1);
  localparam int STK_AW    = $clog2(MAX_NODES);
  localparam int EDGE_AW   = $clog2(EDGE_CAP);
  localparam int TBL_DEPTH = LIFT_LEVELS << NODE_W;
  localparam int TBL_AW    = LVL_W + NODE_W;

  localparam logic signed [WEIGHT_W-1:0] W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic signed [WEIGHT_W-1:0] W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

  // opcodes
  localparam logic [1:0] OP_ADD_EDGE = 2'd0;
  localparam logic [1:0] OP_BUILD    = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;

  // stored edge word
  typedef struct packed {
    logic [NODE_W-1:0]          a;
    logic [NODE_W-1:0]          b;
    logic signed [WEIGHT_W-1:0] w;
  } edge_t;

  // per-node word
  typedef struct packed {
    logic               seen;
    logic [DEPTH_W-1:0] depth;
  } node_ent_t;

  // lifting table word
  typedef struct packed {
    logic [NODE_W-1:0]          anc;
    logic signed [WEIGHT_W-1:0] mn;
    logic signed [WEIGHT_W-1:0] mx;
  } tbl_ent_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLEAR, S_ROOT, S_POP, S_POP_X, S_POP_D,
    S_E_RD, S_E_CHK, S_E_UPD,
    S_F_RD, S_F_P, S_F_WR,
    S_Q_RDU, S_Q_RDV, S_Q_CHK,
    S_L1_RD, S_L1_UPD, S_L1_END,
    S_L2_RDU, S_L2_RDV, S_L2_UPD,
    S_FIN_U, S_FIN_V, S_FIN_W,
    S_OUT
  } tpq_state_t;

  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [LVL_W-1:0] lvl,
                                                 input logic [NODE_W-1:0] n);
    tbl_addr = {lvl, n};
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] smin(
      input logic signed [WEIGHT_W-1:0] x, input logic signed [WEIGHT_W-1:0] y);
    smin = (y < x) ? y : x;
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] smax(
      input logic signed [WEIGHT_W-1:0] x, input logic signed [WEIGHT_W-1:0] y);
    smax = (y > x) ? y : x;
  endfunction

endpackage

>>> rtl/core/tpq_ram.sv
// ----------------------------------------------------------------------------
// tpq_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module tpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/tree_path_min_max_query.sv
// ----------------------------------------------------------------------------
// tree_path_min_max_query
// Stores tree edges, builds binary lifting tables of ancestors and path
// min/max weights, and answers path min/max and lowest common ancestor queries.
// ----------------------------------------------------------------------------
// Edge word: busy stays low. Build: sweep of the node memory, then a walk
//   that pops each node and scans every stored edge for it, then a fill
//   of every node for each table level (levels 1..10).
// Query: ends at once when rejected, after the node memory reads when a node
//   is unreached, else after the level walk through the table memory read port.
// Result on path_min/path_max/meeting_node with done for one cycle, no stall.
// Reset: control state cleared, node_count 1, tables not built; memories keep
//   their contents and a build sweeps the node memory before the walk.
module tree_path_min_max_query (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [1:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         opcode,
  input  logic [tpq_pkg::NODE_W-1:0]         node_a,
  input  logic [tpq_pkg::NODE_W-1:0]         node_b,
  input  logic signed [tpq_pkg::WEIGHT_W-1:0] edge_weight,
  output logic                               done,
  output logic signed [tpq_pkg::WEIGHT_W-1:0] path_min,
  output logic signed [tpq_pkg::WEIGHT_W-1:0] path_max,
  output logic [tpq_pkg::NODE_W-1:0]         meeting_node
);
  import tpq_pkg::*;

  localparam logic [LVL_W-1:0] TOP = LVL_W'(LIFT_LEVELS - 1);

  tpq_state_t state, state_next;

  // control and datapath registers
  logic [NODE_W-1:0]   node_count;
  logic [EDGE_AW-1:0]  edge_count;
  logic                ready;
  logic [NODE_W-1:0]   cnt;
  logic [NODE_AW-1:0]  clr;
  logic [NODE_W-1:0]   sp;
  logic [NODE_W-1:0]   x;
  logic [DEPTH_W-1:0]  dx;
  logic [EDGE_AW-1:0]  e;
  logic [NODE_W-1:0]   oth;
  logic signed [WEIGHT_W-1:0] ow;
  logic [LVL_W-1:0]    j;
  logic [NODE_W-1:0]   i;
  logic signed [WEIGHT_W-1:0] f_mn, f_mx;
  logic [NODE_W-1:0]   u, v;
  logic                su;
  logic [DEPTH_W-1:0]  du;
  logic [DEPTH_W-1:0]  d;
  logic [LVL_W-1:0]    lvl;
  tbl_ent_t            eu;
  logic signed [WEIGHT_W-1:0] lo, hi;
  logic [NODE_W-1:0]   meet;

  // memory ports
  logic               edg_we, node_we, stk_we, tbl_we;
  logic [EDGE_AW-1:0] edg_waddr, edg_raddr;
  edge_t              edg_wdata, edg_rdata;
  logic [NODE_AW-1:0] node_waddr, node_raddr;
  node_ent_t          node_wdata, node_rdata;
  logic [STK_AW-1:0]  stk_waddr, stk_raddr;
  logic [NODE_W-1:0]  stk_wdata, stk_rdata;
  logic [TBL_AW-1:0]  tbl_waddr, tbl_raddr;
  tbl_ent_t           tbl_wdata, tbl_rdata;

  // helper terms
  logic               accept, cfg_wr;
  logic               hit_a, hit_b, edge_ok, e_last, f_last;
  logic [NODE_W-1:0]  other, sp_dec;
  logic [DEPTH_W:0]   step;
  logic               d_ge, a_ok, b_ok, anc_diff;
  logic signed [WEIGHT_W-1:0] lo2, hi2;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign done   = (state == S_OUT);
  assign pready = 1'b1;
  assign prdata = 32'(node_count);
  assign cfg_wr = psel && penable && pwrite && pready;

  assign path_min     = lo;
  assign path_max     = hi;
  assign meeting_node = meet;

  // edge scan decode
  assign hit_a   = (edg_rdata.a == x);
  assign hit_b   = (edg_rdata.b == x);
  assign other   = hit_a ? edg_rdata.b : edg_rdata.a;
  assign edge_ok = (hit_a || hit_b) && (other != '0) && (other <= cnt);
  assign e_last  = ((EDGE_AW+1)'(e) + (EDGE_AW+1)'(1)) == (EDGE_AW+1)'(edge_count);
  assign f_last  = (i == cnt);
  assign sp_dec  = sp - NODE_W'(1);

  // lifting terms
  assign step     = (DEPTH_W+1)'(1) << lvl;
  assign d_ge     = {1'b0, d} >= step;
  assign a_ok     = (node_a != '0) && (node_a <= NODE_W'(MAX_NODES));
  assign b_ok     = (node_b != '0) && (node_b <= NODE_W'(MAX_NODES));
  assign anc_diff = (eu.anc != tbl_rdata.anc);
  assign lo2      = smin(smin(lo, eu.mn), tbl_rdata.mn);
  assign hi2      = smax(smax(hi, eu.mx), tbl_rdata.mx);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory controls
  always_comb begin
    state_next = state;
    edg_we     = 1'b0;
    edg_waddr  = edge_count;
    edg_wdata  = '{a: node_a, b: node_b, w: edge_weight};
    edg_raddr  = e;
    node_we    = 1'b0;
    node_waddr = '0;
    node_wdata = '0;
    node_raddr = '0;
    stk_we     = 1'b0;
    stk_waddr  = sp[STK_AW-1:0];
    stk_wdata  = oth;
    stk_raddr  = sp_dec[STK_AW-1:0];
    tbl_we     = 1'b0;
    tbl_waddr  = '0;
    tbl_wdata  = '0;
    tbl_raddr  = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (opcode)
            OP_ADD_EDGE: edg_we = (edge_count < EDGE_AW'(EDGE_CAP));
            OP_BUILD:    state_next = S_CLEAR;
            OP_QUERY:    state_next = (ready && a_ok && b_ok) ? S_Q_RDU : S_OUT;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        node_we    = 1'b1;
        node_waddr = clr;
        if (clr == NODE_AW'(MAX_NODES)) begin
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        if (cnt != '0) begin
          node_we    = 1'b1;
          node_waddr = NODE_AW'(1);
          node_wdata = '{seen: 1'b1, depth: '0};
          tbl_we     = 1'b1;
          tbl_waddr  = tbl_addr('0, NODE_W'(1));
          tbl_wdata  = '{anc: '0, mn: W_MAX, mx: W_MIN};
          stk_we     = 1'b1;
          stk_waddr  = '0;
          stk_wdata  = NODE_W'(1);
          state_next = S_POP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_POP: state_next = (sp == '0) ? S_F_RD : S_POP_X;
      S_POP_X: begin
        node_raddr = NODE_AW'(stk_rdata);
        state_next = S_POP_D;
      end
      S_POP_D: state_next = (edge_count == '0) ? S_POP : S_E_RD;
      S_E_RD:  state_next = S_E_CHK;
      S_E_CHK: begin
        if (edge_ok) begin
          node_raddr = NODE_AW'(other);
          state_next = S_E_UPD;
        end else begin
          state_next = e_last ? S_POP : S_E_RD;
        end
      end
      S_E_UPD: begin
        // new child: depth, parent entry and push
        if (!node_rdata.seen) begin
          node_we    = 1'b1;
          node_waddr = NODE_AW'(oth);
          node_wdata = '{seen: 1'b1, depth: dx + DEPTH_W'(1)};
          tbl_we     = 1'b1;
          tbl_waddr  = tbl_addr('0, oth);
          tbl_wdata  = '{anc: x, mn: ow, mx: ow};
          stk_we     = 1'b1;
        end
        state_next = e_last ? S_POP : S_E_RD;
      end
      S_F_RD: begin
        tbl_raddr  = tbl_addr(j - LVL_W'(1), i);
        state_next = S_F_P;
      end
      S_F_P: begin
        if (tbl_rdata.anc == '0) begin
          tbl_we     = 1'b1;
          tbl_waddr  = tbl_addr(j, i);
          tbl_wdata  = '{anc: '0, mn: W_MAX, mx: W_MIN};
          state_next = (f_last && j == TOP) ? S_IDLE : S_F_RD;
        end else begin
          tbl_raddr  = tbl_addr(j - LVL_W'(1), tbl_rdata.anc);
          state_next = S_F_WR;
        end
      end
      S_F_WR: begin
        tbl_we     = 1'b1;
        tbl_waddr  = tbl_addr(j, i);
        tbl_wdata  = '{anc: tbl_rdata.anc, mn: smin(f_mn, tbl_rdata.mn),
                       mx: smax(f_mx, tbl_rdata.mx)};
        state_next = (f_last && j == TOP) ? S_IDLE : S_F_RD;
      end
      S_Q_RDU: begin
        node_raddr = NODE_AW'(u);
        state_next = S_Q_RDV;
      end
      S_Q_RDV: begin
        node_raddr = NODE_AW'(v);
        state_next = S_Q_CHK;
      end
      S_Q_CHK: state_next = (su && node_rdata.seen) ? S_L1_RD : S_OUT;
      S_L1_RD: begin
        if (d_ge) begin
          tbl_raddr  = tbl_addr(lvl, u);
          state_next = S_L1_UPD;
        end else if (lvl == '0) begin
          state_next = S_L1_END;
        end
      end
      S_L1_UPD: state_next = (lvl == '0) ? S_L1_END : S_L1_RD;
      S_L1_END: state_next = (u == v) ? S_OUT : S_L2_RDU;
      S_L2_RDU: begin
        tbl_raddr  = tbl_addr(lvl, u);
        state_next = S_L2_RDV;
      end
      S_L2_RDV: begin
        tbl_raddr  = tbl_addr(lvl, v);
        state_next = S_L2_UPD;
      end
      S_L2_UPD: begin
        if (anc_diff && lvl == TOP) begin
          state_next = S_L2_RDU;
        end else begin
          state_next = (lvl == '0) ? S_FIN_U : S_L2_RDU;
        end
      end
      S_FIN_U: begin
        tbl_raddr  = tbl_addr('0, u);
        state_next = S_FIN_V;
      end
      S_FIN_V: begin
        tbl_raddr  = tbl_addr('0, v);
        state_next = S_FIN_W;
      end
      S_FIN_W: state_next = S_OUT;
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_W'(1);
      edge_count <= '0;
      ready      <= 1'b0;
    end else begin
      if (cfg_wr) begin
        node_count <= pwdata[NODE_W-1:0];
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (opcode)
              OP_ADD_EDGE: begin
                if (edge_count < EDGE_AW'(EDGE_CAP)) begin
                  edge_count <= edge_count + EDGE_AW'(1);
                end
              end
              OP_BUILD: begin
                cnt <= (node_count > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES)
                                                         : node_count;
                clr <= '0;
              end
              OP_QUERY: begin
                u    <= node_a;
                v    <= node_b;
                lo   <= W_MAX;
                hi   <= W_MIN;
                meet <= '0;
              end
              default: ;
            endcase
          end
        end
        S_CLEAR: clr <= clr + NODE_AW'(1);
        S_ROOT: begin
          sp <= (cnt != '0) ? NODE_W'(1) : '0;
          j  <= LVL_W'(1);
          i  <= NODE_W'(1);
          if (cnt == '0) begin
            ready <= 1'b1;
          end
        end
        S_POP: begin
          if (sp != '0) begin
            sp <= sp_dec;
          end
        end
        S_POP_X: x <= stk_rdata;
        S_POP_D: begin
          dx <= node_rdata.depth;
          e  <= '0;
        end
        S_E_CHK: begin
          oth <= other;
          ow  <= edg_rdata.w;
          if (!edge_ok && !e_last) begin
            e <= e + EDGE_AW'(1);
          end
        end
        S_E_UPD: begin
          if (!node_rdata.seen) begin
            sp <= sp + NODE_W'(1);
          end
          if (!e_last) begin
            e <= e + EDGE_AW'(1);
          end
        end
        S_F_P: begin
          f_mn <= tbl_rdata.mn;
          f_mx <= tbl_rdata.mx;
          if (tbl_rdata.anc == '0) begin
            if (f_last) begin
              if (j == TOP) begin
                ready <= 1'b1;
              end else begin
                j <= j + LVL_W'(1);
                i <= NODE_W'(1);
              end
            end else begin
              i <= i + NODE_W'(1);
            end
          end
        end
        S_F_WR: begin
          if (f_last) begin
            if (j == TOP) begin
              ready <= 1'b1;
            end else begin
              j <= j + LVL_W'(1);
              i <= NODE_W'(1);
            end
          end else begin
            i <= i + NODE_W'(1);
          end
        end
        S_Q_RDV: begin
          su <= node_rdata.seen;
          du <= node_rdata.depth;
        end
        S_Q_CHK: begin
          // deeper node goes to u
          lvl <= TOP;
          if (du < node_rdata.depth) begin
            u <= v;
            v <= u;
            d <= node_rdata.depth - du;
          end else begin
            d <= du - node_rdata.depth;
          end
        end
        S_L1_RD: begin
          if (!d_ge && lvl != '0) begin
            lvl <= lvl - LVL_W'(1);
          end
        end
        S_L1_UPD: begin
          lo <= smin(lo, tbl_rdata.mn);
          hi <= smax(hi, tbl_rdata.mx);
          u  <= tbl_rdata.anc;
          d  <= d - step[DEPTH_W-1:0];
          if (lvl != TOP && lvl != '0) begin
            lvl <= lvl - LVL_W'(1);
          end
        end
        S_L1_END: begin
          if (u == v) begin
            meet <= u;
          end else begin
            lvl <= TOP;
          end
        end
        S_L2_RDV: eu <= tbl_rdata;
        S_L2_UPD: begin
          if (anc_diff) begin
            lo <= lo2;
            hi <= hi2;
            u  <= eu.anc;
            v  <= tbl_rdata.anc;
            if (lvl != TOP && lvl != '0) begin
              lvl <= lvl - LVL_W'(1);
            end
          end else if (lvl != '0) begin
            lvl <= lvl - LVL_W'(1);
          end
        end
        S_FIN_V: begin
          eu <= tbl_rdata;
          lo <= smin(lo, tbl_rdata.mn);
          hi <= smax(hi, tbl_rdata.mx);
        end
        S_FIN_W: begin
          lo   <= smin(lo, tbl_rdata.mn);
          hi   <= smax(hi, tbl_rdata.mx);
          meet <= eu.anc;
        end
        default: ;
      endcase
    end
  end

  // edge store
  tpq_ram #(.WIDTH($bits(edge_t)), .DEPTH(EDGE_CAP)) u_edge_ram (
    .clk   (clk),
    .we    (edg_we),
    .waddr (edg_waddr),
    .wdata (edg_wdata),
    .raddr (edg_raddr),
    .rdata (edg_rdata)
  );

  // reached bit and depth per node
  tpq_ram #(.WIDTH($bits(node_ent_t)), .DEPTH(MAX_NODES + 1)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  // walk stack
  tpq_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // ancestor, min and max lifting tables
  tpq_ram #(.WIDTH($bits(tbl_ent_t)), .DEPTH(TBL_DEPTH)) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

`ifndef ASSERT_OFF
  // a result word is only shown while the block is busy
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  // result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");

  // a build word makes the block busy
  a_build_busy: assert property (@(posedge clk) disable iff (rst)
      (accept && opcode == OP_BUILD) |=> busy)
    else $error("build did not start");

  // edge store never overfills
  a_edge_cap: assert property (@(posedge clk) disable iff (rst)
      edg_we |-> (edge_count < EDGE_AW'(EDGE_CAP)))
    else $error("edge store overflow");
`endif

endmodule
